### rtl/content_length_frame_parser_assert.svh
// Assertion macros used by the parser RTL.
`ifndef CONTENT_LENGTH_FRAME_PARSER_ASSERT_SVH
`define CONTENT_LENGTH_FRAME_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CLFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CLFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`else

`define CLFP_ASSERT_NOW(label, clk, rst, ante, cons)
`define CLFP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/clfp_pkg.sv
`timescale 1ns / 1ps

package clfp_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_EOF_HDR   = 3'd1;
   localparam logic [2:0] ERR_MALFORMED = 3'd2;
   localparam logic [2:0] ERR_OVERCAP   = 3'd3;
   localparam logic [2:0] ERR_NO_LENGTH = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED = 3'd5;

   // Frame phase.
   localparam logic PH_HEADER = 1'b0;
   localparam logic PH_BODY   = 1'b1;

   // Header line parsing modes.
   localparam logic [2:0] LM_PREFIX = 3'd0;
   localparam logic [2:0] LM_SPACES = 3'd1;
   localparam logic [2:0] LM_DIGITS = 3'd2;
   localparam logic [2:0] LM_OTHER  = 3'd3;
   localparam logic [2:0] LM_FAILED = 3'd4;

   // Error recorded against the current line.
   localparam logic [1:0] LE_NONE      = 2'd0;
   localparam logic [1:0] LE_MALFORMED = 2'd1;
   localparam logic [1:0] LE_OVERCAP   = 2'd2;

   // Characters of interest.
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Length of the "Content-Length:" key.
   localparam logic [3:0] KEY_LEN = 4'd15;

   typedef logic [7:0] byte_type;

   // Character of the key at a given position.
   function automatic byte_type key_char(input logic [3:0] pos);
      byte_type c;
      case (pos)
         4'd0: c = "C";
         4'd1: c = "o";
         4'd2: c = "n";
         4'd3: c = "t";
         4'd4: c = "e";
         4'd5: c = "n";
         4'd6: c = "t";
         4'd7: c = "-";
         4'd8: c = "L";
         4'd9: c = "e";
         4'd10: c = "n";
         4'd11: c = "g";
         4'd12: c = "t";
         4'd13: c = "h";
         4'd14: c = ":";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### rtl/content_length_frame_parser.sv
`timescale 1ns / 1ps
// A result is registered: each accepted byte waits in the input register, and its result
// enters the output register when the item advances. One item per cycle while rsp_stall is
// low; a byte then follows the previous one with no gap.
// The per-byte path is one key-character compare plus one multiply-by-ten add and cap compare.
// Reset is synchronous and active high: both pipeline slots empty, parser at a fresh header
// block, and the length cap back to 16777216 (truncated to LENGTH_BITS).
`include "content_length_frame_parser_assert.svh"

module content_length_frame_parser #(
   parameter int LENGTH_BITS = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   // Configuration write channel: the length cap.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LENGTH_BITS-1:0] csr_max_frame_length,
   // Input byte stream.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_byte_value,
   input  logic                   req_end_of_input,
   // Results.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_result_kind,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last_of_frame,
   output logic [2:0]             rsp_error_code,
   output logic [LENGTH_BITS-1:0] rsp_frame_length
);

   // Room for one more decimal digit on top of any value that is still within the cap.
   localparam int AccW = LENGTH_BITS + 4;
   localparam logic [LENGTH_BITS-1:0] CapReset = LENGTH_BITS'(64'd16777216);
   localparam logic [LENGTH_BITS-1:0] LenOne   = LENGTH_BITS'(1);

   // The cap register. Writes must be issued only while the parser is idle; the block itself
   // does not enforce this. It is always ready.
   logic [LENGTH_BITS-1:0] cap_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_max_frame_length;
      end
   end

   // Input register: holds one accepted item until it is folded into the parser state.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;
   logic       adv;

   // Output register: holds one result until the consumer takes it.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             kind_ff;
   logic [7:0]             obyte_ff;
   logic                   last_ff;
   logic [2:0]             code_ff;
   logic [LENGTH_BITS-1:0] flen_ff;

   // An item is processed when the result slot is free or is being emptied this cycle.
   // Items that produce no result take the same path so ordering stays trivial.
   assign adv       = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !adv;

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_value;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   // Parser state.
   logic                   phase_ff, phase_in;
   logic [2:0]             mode_ff, mode_in;
   logic [3:0]             pos_ff, pos_in;
   logic                   pcr_ff, pcr_in;
   logic                   has_bytes_ff, has_bytes_in;
   logic                   header_seen_ff, header_seen_in;
   logic                   known_ff, known_in;
   logic [1:0]             lerr_ff, lerr_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;

   // Result of the current item, valid when r_v is set.
   logic                   r_v;
   logic [1:0]             r_kind;
   logic                   r_last;
   logic [2:0]             r_code;
   logic [LENGTH_BITS-1:0] r_flen;

   // Working values for the header path.
   logic                   apply_cr;
   logic [2:0]             mode1;
   logic [1:0]             lerr1;
   logic                   has1;
   logic                   seen1;
   logic                   is_digit;
   logic [3:0]             digit_val;
   logic [LENGTH_BITS-1:0] acc_base;
   logic [AccW-1:0]        acc_next;
   logic                   over_cap;
   logic [2:0]             fin_code;
   logic [2:0]             end_code;

   always_comb begin
      is_digit  = in_byte_ff inside {[clfp_pkg::CHAR_ZERO:clfp_pkg::CHAR_NINE]};
      digit_val = 4'(in_byte_ff - clfp_pkg::CHAR_ZERO);
      // The first digit after the key starts from zero; later digits scale the value so far.
      acc_base  = (mode_ff == clfp_pkg::LM_SPACES) ? '0 : acc_ff;
      acc_next  = (AccW'(acc_base) << 3) + (AccW'(acc_base) << 1) + AccW'(digit_val);
      over_cap  = acc_next > AccW'(cap_ff);
   end

   always_comb begin
      phase_in       = phase_ff;
      mode_in        = mode_ff;
      pos_in         = pos_ff;
      pcr_in         = pcr_ff;
      has_bytes_in   = has_bytes_ff;
      header_seen_in = header_seen_ff;
      known_in       = known_ff;
      lerr_in        = lerr_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      r_v            = 1'b0;
      r_kind         = clfp_pkg::KIND_PAYLOAD;
      r_last         = 1'b0;
      r_code         = clfp_pkg::ERR_NONE;
      r_flen         = '0;

      // A carriage return that turns out not to precede a line feed is an ordinary line
      // byte. It never matches the key, a space or a digit, so its only effect is to end
      // prefix matching or to spoil a length value.
      apply_cr = pcr_ff && (in_eoi_ff || in_byte_ff != clfp_pkg::CHAR_LF);
      mode1    = mode_ff;
      lerr1    = lerr_ff;
      has1     = has_bytes_ff;
      seen1    = header_seen_ff;
      if (apply_cr) begin
         has1  = 1'b1;
         seen1 = 1'b1;
         case (mode_ff)
            clfp_pkg::LM_PREFIX: begin
               mode1 = clfp_pkg::LM_OTHER;
            end
            clfp_pkg::LM_SPACES, clfp_pkg::LM_DIGITS: begin
               mode1 = clfp_pkg::LM_FAILED;
               lerr1 = clfp_pkg::LE_MALFORMED;
            end
            default: begin
            end
         endcase
      end

      // Closing a line that is still in the spaces mode means the key had no digits.
      if (mode1 == clfp_pkg::LM_SPACES || lerr1 == clfp_pkg::LE_MALFORMED) begin
         fin_code = clfp_pkg::ERR_MALFORMED;
      end else if (lerr1 == clfp_pkg::LE_OVERCAP) begin
         fin_code = clfp_pkg::ERR_OVERCAP;
      end else begin
         fin_code = clfp_pkg::ERR_NONE;
      end
      end_code = (fin_code != clfp_pkg::ERR_NONE) ? fin_code : clfp_pkg::ERR_EOF_HDR;

      if (adv) begin
         if (phase_ff == clfp_pkg::PH_BODY) begin
            r_v    = 1'b1;
            r_flen = acc_ff;
            if (in_eoi_ff) begin
               r_kind = clfp_pkg::KIND_ERROR;
               r_code = clfp_pkg::ERR_TRUNCATED;
            end else begin
               if (rem_ff <= LenOne) begin
                  r_last = 1'b1;
               end else begin
                  rem_in = rem_ff - LenOne;
               end
            end
         end else if (in_eoi_ff) begin
            r_v = 1'b1;
            if (has1) begin
               r_kind = clfp_pkg::KIND_ERROR;
               r_code = end_code;
            end else if (seen1) begin
               r_kind = clfp_pkg::KIND_ERROR;
               r_code = clfp_pkg::ERR_EOF_HDR;
            end else begin
               r_kind = clfp_pkg::KIND_END;
            end
         end else if (pcr_ff && in_byte_ff == clfp_pkg::CHAR_LF
                      || in_byte_ff == clfp_pkg::CHAR_LF) begin
            // End of line. No pending carriage return was folded in, so the registered
            // line state is the state of the line being closed.
            pcr_in = 1'b0;
            if (has_bytes_ff) begin
               if (fin_code != clfp_pkg::ERR_NONE) begin
                  r_v    = 1'b1;
                  r_kind = clfp_pkg::KIND_ERROR;
                  r_code = fin_code;
               end else begin
                  if (mode_ff == clfp_pkg::LM_DIGITS) begin
                     known_in = 1'b1;
                     rem_in   = acc_ff;
                  end
                  mode_in      = clfp_pkg::LM_PREFIX;
                  pos_in       = '0;
                  has_bytes_in = 1'b0;
                  lerr_in      = clfp_pkg::LE_NONE;
               end
            end else if (!known_ff) begin
               r_v    = 1'b1;
               r_kind = clfp_pkg::KIND_ERROR;
               r_code = clfp_pkg::ERR_NO_LENGTH;
            end else if (rem_ff == '0) begin
               r_v    = 1'b1;
               r_kind = clfp_pkg::KIND_EMPTY;
               r_last = 1'b1;
            end else begin
               // Blank line with a known length: the body starts. The accumulator now
               // carries the declared length for the frame_length field.
               mode_in  = clfp_pkg::LM_PREFIX;
               pos_in   = '0;
               lerr_in  = clfp_pkg::LE_NONE;
               acc_in   = rem_ff;
               phase_in = clfp_pkg::PH_BODY;
            end
         end else begin
            // Ordinary header byte, applied after any pending carriage return.
            mode_in        = mode1;
            lerr_in        = lerr1;
            has_bytes_in   = has1;
            header_seen_in = seen1;
            if (in_byte_ff == clfp_pkg::CHAR_CR) begin
               pcr_in = 1'b1;
            end else begin
               pcr_in         = 1'b0;
               has_bytes_in   = 1'b1;
               header_seen_in = 1'b1;
               case (mode1)
                  clfp_pkg::LM_PREFIX: begin
                     if (pos_ff < clfp_pkg::KEY_LEN
                         && in_byte_ff == clfp_pkg::key_char(pos_ff)) begin
                        pos_in = pos_ff + 4'd1;
                        if (pos_ff + 4'd1 == clfp_pkg::KEY_LEN) begin
                           mode_in = clfp_pkg::LM_SPACES;
                        end
                     end else begin
                        mode_in = clfp_pkg::LM_OTHER;
                     end
                  end
                  clfp_pkg::LM_SPACES, clfp_pkg::LM_DIGITS: begin
                     if (mode1 == clfp_pkg::LM_SPACES && in_byte_ff == clfp_pkg::CHAR_SPACE) begin
                        mode_in = mode1;
                     end else if (is_digit) begin
                        // A value above the cap is never scaled again, so the truncated
                        // copy kept here is only ever read when it is within the cap.
                        acc_in = acc_next[LENGTH_BITS-1:0];
                        if (over_cap) begin
                           mode_in = clfp_pkg::LM_FAILED;
                           lerr_in = clfp_pkg::LE_OVERCAP;
                        end else begin
                           mode_in = clfp_pkg::LM_DIGITS;
                        end
                     end else begin
                        mode_in = clfp_pkg::LM_FAILED;
                        lerr_in = clfp_pkg::LE_MALFORMED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Any result other than a body byte that is not the last one ends the frame.
         if (r_v && !(r_kind == clfp_pkg::KIND_PAYLOAD && !r_last)) begin
            phase_in       = clfp_pkg::PH_HEADER;
            mode_in        = clfp_pkg::LM_PREFIX;
            pos_in         = '0;
            pcr_in         = 1'b0;
            has_bytes_in   = 1'b0;
            header_seen_in = 1'b0;
            known_in       = 1'b0;
            lerr_in        = clfp_pkg::LE_NONE;
            acc_in         = '0;
            rem_in         = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= clfp_pkg::PH_HEADER;
         mode_ff        <= clfp_pkg::LM_PREFIX;
         pos_ff         <= '0;
         pcr_ff         <= 1'b0;
         has_bytes_ff   <= 1'b0;
         header_seen_ff <= 1'b0;
         known_ff       <= 1'b0;
         lerr_ff        <= clfp_pkg::LE_NONE;
         acc_ff         <= '0;
         rem_ff         <= '0;
      end else begin
         phase_ff       <= phase_in;
         mode_ff        <= mode_in;
         pos_ff         <= pos_in;
         pcr_ff         <= pcr_in;
         has_bytes_ff   <= has_bytes_in;
         header_seen_ff <= header_seen_in;
         known_ff       <= known_in;
         lerr_ff        <= lerr_in;
         acc_ff         <= acc_in;
         rem_ff         <= rem_in;
      end
   end

   // Result register.
   always_comb begin
      if (adv) begin
         rsp_valid_in = r_v;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && r_v) begin
         kind_ff  <= r_kind;
         obyte_ff <= (r_kind == clfp_pkg::KIND_PAYLOAD) ? in_byte_ff : 8'h00;
         last_ff  <= r_last;
         code_ff  <= r_code;
         flen_ff  <= r_flen;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_out_byte      = obyte_ff;
   assign rsp_last_of_frame = last_ff;
   assign rsp_error_code    = code_ff;
   assign rsp_frame_length  = flen_ff;

   // Terms used by the checks below.
   logic line_failed;
   logic kind_is_error;
   logic code_is_set;
   logic err_taken;
   logic frame_fresh;

   assign line_failed   = mode_ff == clfp_pkg::LM_FAILED;
   assign kind_is_error = kind_ff == clfp_pkg::KIND_ERROR;
   assign code_is_set   = code_ff != clfp_pkg::ERR_NONE;
   assign err_taken     = adv && r_v && r_kind == clfp_pkg::KIND_ERROR;
   assign frame_fresh   = phase_ff == clfp_pkg::PH_HEADER && !header_seen_ff && !known_ff;

   // While in the body at least one byte is still due.
   `CLFP_ASSERT_NOW(a_body_has_bytes, clock, reset, phase_ff == clfp_pkg::PH_BODY, rem_ff != '0)
   // A recorded line error always parks the line in the failed mode.
   `CLFP_ASSERT_NOW(a_err_parks_line, clock, reset, lerr_ff != clfp_pkg::LE_NONE, line_failed)
   // Error results carry a code, other results carry none.
   `CLFP_ASSERT_NOW(a_code_matches_kind, clock, reset, rsp_valid_ff, kind_is_error == code_is_set)
   // The key match position never runs past the key.
   `CLFP_ASSERT_NOW(a_pos_in_key, clock, reset, 1'b1, pos_ff <= clfp_pkg::KEY_LEN)
   // An error restarts the parser at a fresh header block.
   `CLFP_ASSERT_NEXT(a_err_restarts, clock, reset, err_taken, frame_fresh)

endmodule

### dv/content_length_frame_parser_tb.sv
`timescale 1ns / 1ps

module content_length_frame_parser_tb;

   localparam int LB = 25;
   // The result register sits behind the input register, and the drain covers both.
   localparam int DRAIN_CYCLES = 6;
   localparam int PRESSURE_HOLD = 200;
   localparam int CYCLE_LIMIT = 200000;
   localparam string LENGTH_KEY = "Content-Length:";

   typedef struct packed {
      logic [1:0]    kind;
      logic [7:0]    data;
      logic          last;
      logic [2:0]    code;
      logic [LB-1:0] length;
   } parser_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [LB-1:0] csr_max_frame_length = '0;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_byte_value = '0;
   logic          req_end_of_input = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [1:0]    rsp_result_kind;
   logic [7:0]    rsp_out_byte;
   logic          rsp_last_of_frame;
   logic [2:0]    rsp_error_code;
   logic [LB-1:0] rsp_frame_length;

   content_length_frame_parser i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_frame_length (csr_max_frame_length),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_byte_value       (req_byte_value),
      .req_end_of_input     (req_end_of_input),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_last_of_frame    (rsp_last_of_frame),
      .rsp_error_code       (rsp_error_code),
      .rsp_frame_length     (rsp_frame_length)
   );

   always #1 clock = ~clock;

   // Results that the parser still owes us, oldest first.
   parser_result_type expected_results[$];
   int             failures = 0;
   int             cycle_count = 0;
   int unsigned    items_sent = 0;
   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;
   // The test bumps the request count; the receiver process notices and starts a long hold.
   int             pressure_requests = 0;
   int             pressure_served = 0;
   int             hold_left = 0;

   // Our own copy of the parser state, advanced once per accepted item.
   logic [LB-1:0]   length_cap = 25'd16777216;
   bit              in_body;
   logic [2:0]      line_state;
   logic [3:0]      key_pos;
   bit              cr_held;
   bit              line_nonempty;
   bit              saw_header;
   bit              have_length;
   logic [1:0]      line_fault;
   // Holds the value of the length line in the headers and the declared length in the body.
   longint unsigned value_acc;
   // Holds the committed length in the headers and the bytes still due in the body.
   longint unsigned bytes_left;

   function automatic parser_result_type make_result(input logic [1:0] kind,
                                                     input logic [7:0] data, input logic last,
                                                     input logic [2:0] code,
                                                     input logic [LB-1:0] length);
      parser_result_type r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      r.code = code;
      r.length = length;
      return r;
   endfunction

   function automatic void reset_line();
      line_state = clfp_pkg::LM_PREFIX;
      key_pos = '0;
      line_nonempty = 1'b0;
      line_fault = clfp_pkg::LE_NONE;
   endfunction

   // Every error and every end of input drops the parser back to a fresh header block.
   function automatic void restart_frame();
      reset_line();
      in_body = 1'b0;
      cr_held = 1'b0;
      saw_header = 1'b0;
      have_length = 1'b0;
      value_acc = 0;
      bytes_left = 0;
   endfunction

   function automatic void mark_line_bad(input logic [1:0] why);
      line_fault = why;
      line_state = clfp_pkg::LM_FAILED;
   endfunction

   function automatic void accumulate_digit(input logic [7:0] digit);
      value_acc = value_acc * 10 + digit;
      if (value_acc > length_cap) mark_line_bad(clfp_pkg::LE_OVERCAP);
   endfunction

   function automatic void absorb_line_byte(input logic [7:0] b);
      bit is_digit;
      is_digit = (b >= clfp_pkg::CHAR_ZERO) && (b <= clfp_pkg::CHAR_NINE);
      line_nonempty = 1'b1;
      saw_header = 1'b1;
      case (line_state)
         clfp_pkg::LM_PREFIX: begin
            if (key_pos < clfp_pkg::KEY_LEN && b == LENGTH_KEY[key_pos]) begin
               key_pos = key_pos + 1'b1;
               if (key_pos >= clfp_pkg::KEY_LEN) line_state = clfp_pkg::LM_SPACES;
            end else begin
               line_state = clfp_pkg::LM_OTHER;
            end
         end
         clfp_pkg::LM_SPACES: begin
            if (is_digit) begin
               line_state = clfp_pkg::LM_DIGITS;
               value_acc = 0;
               accumulate_digit(b - clfp_pkg::CHAR_ZERO);
            end else if (b != clfp_pkg::CHAR_SPACE) begin
               mark_line_bad(clfp_pkg::LE_MALFORMED);
            end
         end
         clfp_pkg::LM_DIGITS: begin
            if (is_digit) accumulate_digit(b - clfp_pkg::CHAR_ZERO);
            else mark_line_bad(clfp_pkg::LE_MALFORMED);
         end
         default: ;
      endcase
   endfunction

   // Closes a line that holds bytes. A key with no digits after it counts as malformed.
   function automatic logic [2:0] close_line();
      logic [2:0] code;
      code = clfp_pkg::ERR_NONE;
      if (line_state == clfp_pkg::LM_SPACES) mark_line_bad(clfp_pkg::LE_MALFORMED);
      if (line_fault == clfp_pkg::LE_MALFORMED) begin
         code = clfp_pkg::ERR_MALFORMED;
      end else if (line_fault == clfp_pkg::LE_OVERCAP) begin
         code = clfp_pkg::ERR_OVERCAP;
      end else if (line_state == clfp_pkg::LM_DIGITS) begin
         have_length = 1'b1;
         bytes_left = value_acc[LB-1:0];
      end
      reset_line();
      return code;
   endfunction

   function automatic bit handle_line_feed(output parser_result_type r);
      logic [2:0] code;
      r = '0;
      if (line_nonempty) begin
         code = close_line();
         if (code == clfp_pkg::ERR_NONE) return 1'b0;
         restart_frame();
         r = make_result(clfp_pkg::KIND_ERROR, 8'h00, 1'b0, code, '0);
         return 1'b1;
      end
      // An empty line ends the header block.
      if (!have_length) begin
         restart_frame();
         r = make_result(clfp_pkg::KIND_ERROR, 8'h00, 1'b0, clfp_pkg::ERR_NO_LENGTH, '0);
         return 1'b1;
      end
      if (bytes_left == 0) begin
         restart_frame();
         r = make_result(clfp_pkg::KIND_EMPTY, 8'h00, 1'b1, clfp_pkg::ERR_NONE, '0);
         return 1'b1;
      end
      reset_line();
      value_acc = bytes_left;
      in_body = 1'b1;
      return 1'b0;
   endfunction

   // Advances the parser copy by one item. Returns 1 when the item causes a result.
   function automatic bit predict_step(input logic [7:0] b, input logic eoi,
                                       output parser_result_type r);
      logic [2:0] code;
      r = '0;
      if (in_body) begin
         if (eoi) begin
            r = make_result(clfp_pkg::KIND_ERROR, 8'h00, 1'b0, clfp_pkg::ERR_TRUNCATED,
                            value_acc[LB-1:0]);
            restart_frame();
         end else if (bytes_left <= 1) begin
            r = make_result(clfp_pkg::KIND_PAYLOAD, b, 1'b1, clfp_pkg::ERR_NONE,
                            value_acc[LB-1:0]);
            restart_frame();
         end else begin
            bytes_left = bytes_left - 1;
            r = make_result(clfp_pkg::KIND_PAYLOAD, b, 1'b0, clfp_pkg::ERR_NONE,
                            value_acc[LB-1:0]);
         end
         return 1'b1;
      end
      if (eoi) begin
         // A CR that was waiting for its LF becomes an ordinary line byte.
         if (cr_held) begin
            cr_held = 1'b0;
            absorb_line_byte(clfp_pkg::CHAR_CR);
         end
         if (line_nonempty) begin
            code = close_line();
            r = make_result(clfp_pkg::KIND_ERROR, 8'h00, 1'b0,
                            (code != clfp_pkg::ERR_NONE) ? code : clfp_pkg::ERR_EOF_HDR, '0);
         end else if (saw_header) begin
            r = make_result(clfp_pkg::KIND_ERROR, 8'h00, 1'b0, clfp_pkg::ERR_EOF_HDR, '0);
         end else begin
            r = make_result(clfp_pkg::KIND_END, 8'h00, 1'b0, clfp_pkg::ERR_NONE, '0);
         end
         restart_frame();
         return 1'b1;
      end
      if (cr_held) begin
         cr_held = 1'b0;
         if (b == clfp_pkg::CHAR_LF) return handle_line_feed(r);
         absorb_line_byte(clfp_pkg::CHAR_CR);
      end
      if (b == clfp_pkg::CHAR_CR) begin
         cr_held = 1'b1;
         return 1'b0;
      end
      if (b == clfp_pkg::CHAR_LF) return handle_line_feed(r);
      absorb_line_byte(b);
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   // Each result is taken at the edge where valid is high and our stall is low.
   always @(posedge clock) begin : check_results
      parser_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result of kind %0d arrived with no expectation pending", rsp_result_kind);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("rsp_result_kind", 64'(want.kind), 64'(rsp_result_kind));
            check_field("rsp_out_byte", 64'(want.data), 64'(rsp_out_byte));
            check_field("rsp_last_of_frame", 64'(want.last), 64'(rsp_last_of_frame));
            check_field("rsp_error_code", 64'(want.code), 64'(rsp_error_code));
            check_field("rsp_frame_length", 64'(want.length), 64'(rsp_frame_length));
         end
      end
   end

   // Receiver: random stalls at the current rate, or a long hold when the test asks for one.
   always @(posedge clock) begin
      if (pressure_requests != pressure_served) begin
         pressure_served <= pressure_requests;
         hold_left <= PRESSURE_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("content_length_frame_parser_tb NOT OK");
         $finish;
      end
   end

   // Offers one item and returns at the edge that accepts it. Valid stays high afterward,
   // so the following item can go out back to back. Each cycle the sender idles at the
   // current rate before it offers the item.
   task automatic send_item(input logic [7:0] value, input logic eoi);
      parser_result_type outcome;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= value;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (predict_step(value, eoi, outcome)) expected_results.push_back(outcome);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_line_end();
      if ($urandom_range(0, 1)) send_item(clfp_pkg::CHAR_CR, 1'b0);
      send_item(clfp_pkg::CHAR_LF, 1'b0);
   endtask

   // The byte that goes with the end marker is random, since the parser ignores it.
   task automatic send_end_marker();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Lets the block go quiet: nothing in flight and no result owed.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_length_cap(input logic [LB-1:0] value);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_max_frame_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      length_cap = value;
   endtask

   function automatic logic [7:0] pick_noise_byte();
      case ($urandom_range(0, 3))
         0: return clfp_pkg::CHAR_CR;
         1: return clfp_pkg::CHAR_LF;
         2: return clfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly small lengths, plus the cap itself, one past it, and very long declared bodies.
   function automatic int unsigned pick_length();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) return $urandom_range(0, 5);
      if (pick == 6) return 32'(length_cap);
      if (pick == 7) return 32'(length_cap) + 1;
      if (pick == 8) return $urandom_range(17, 16777216);
      return 16777216;
   endfunction

   // A header line that never sets the length.
   task automatic send_filler_line();
      case ($urandom_range(0, 4))
         0: send_text("Content-Type: text/plain");
         1: send_text("content-length: 7");
         2: send_text("Content-Length");
         3: repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(33, 126)), 1'b0);
         default: begin
            // A CR that is not followed by LF stays inside the line.
            send_item("X", 1'b0);
            send_item(clfp_pkg::CHAR_CR, 1'b0);
            send_item("Y", 1'b0);
         end
      endcase
      send_line_end();
   endtask

   task automatic send_length_line(input int unsigned len);
      send_text(LENGTH_KEY);
      repeat ($urandom_range(0, 2)) send_item(clfp_pkg::CHAR_SPACE, 1'b0);
      if ($urandom_range(0, 7) == 0) send_text("00");
      send_text($sformatf("%0d", len));
      send_line_end();
   endtask

   task automatic send_malformed_line();
      send_text(LENGTH_KEY);
      case ($urandom_range(0, 4))
         0: send_text(" 12x");
         1: send_text(" ");
         2: send_text("+5");
         3: send_text(" 1 2");
         default: send_text("99999999999x");
      endcase
   endtask

   // The stream ends while the parser is still inside the header block.
   task automatic send_cut_header();
      case ($urandom_range(0, 4))
         0: send_text("Content-Le");
         1: send_text("Content-Length: 3");
         2: begin
            send_text("Content-Length: 3");
            send_item(clfp_pkg::CHAR_CR, 1'b0);
         end
         3: send_text("Content-Length:x");
         default: send_length_line($urandom_range(0, 5));
      endcase
      send_end_marker();
   endtask

   // One frame: mostly well formed with random content, the rest noise or broken frames.
   task automatic send_random_frame();
      int unsigned flavor;
      int unsigned len;
      int unsigned cut;
      flavor = $urandom_range(0, 99);
      if (flavor < 8) begin
         repeat ($urandom_range(1, 6)) send_item(pick_noise_byte(), 1'b0);
         if ($urandom_range(0, 1)) send_end_marker();
         return;
      end
      repeat ($urandom_range(0, 2)) send_filler_line();
      if (flavor < 15) begin
         send_line_end();
         return;
      end
      if (flavor < 22) begin
         send_malformed_line();
         send_line_end();
         send_line_end();
         return;
      end
      if (flavor < 28) begin
         send_cut_header();
         return;
      end
      // Sometimes an earlier length line that the later one overrides.
      if ($urandom_range(0, 4) == 0) send_length_line($urandom_range(0, 9));
      len = pick_length();
      send_length_line(len);
      send_line_end();
      // An over-cap length has already failed, so there is no body to send.
      if (len > length_cap) return;
      if (len <= 16 && $urandom_range(0, 9) != 0) begin
         repeat (len) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         cut = (len > 3) ? $urandom_range(0, 3) : $urandom_range(0, len);
         repeat (cut) send_item(8'($urandom_range(0, 255)), 1'b0);
         send_end_marker();
      end
      if ($urandom_range(0, 11) == 0) send_end_marker();
   endtask

   // Short cases that need no length key, then the smallest empty frame.
   task automatic test_directed_cases();
      // An end marker on an untouched stream is a clean end.
      send_end_marker();
      // A blank line with no length header.
      send_item(clfp_pkg::CHAR_LF, 1'b0);
      // The stream ends while a CR is still waiting for its LF.
      send_item("a", 1'b0);
      send_item(clfp_pkg::CHAR_CR, 1'b0);
      send_end_marker();
      // The stream ends between lines after a line was seen.
      send_item("b", 1'b0);
      send_item(clfp_pkg::CHAR_LF, 1'b0);
      send_end_marker();
      // A zero length gives an empty frame.
      send_text("Content-Length:0");
      send_item(clfp_pkg::CHAR_CR, 1'b0);
      send_item(clfp_pkg::CHAR_LF, 1'b0);
      send_item(clfp_pkg::CHAR_LF, 1'b0);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [LB-1:0] cap, input int unsigned count);
      int unsigned start;
      write_length_cap(cap);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      start = items_sent;
      while (items_sent - start < count) send_random_frame();
      send_end_marker();
   endtask

   // The receiver holds off for a long stretch at the start of a body, so the pipeline
   // fills and the parser has to stall its input.
   task automatic test_backpressure();
      write_length_cap(25'd16777215);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_text("Content-Length: 48");
      send_line_end();
      send_line_end();
      pressure_requests++;
      repeat (48) send_item(8'($urandom_range(0, 255)), 1'b0);
      repeat (3) send_random_frame();
      send_end_marker();
   endtask

   initial begin
      restart_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic(31, 70, 25'd16777216, 230);
      test_random_traffic(70, 31, 25'd1, 230);
      test_random_traffic(0, 0, LB'($urandom_range(2, 40)), 230);
      test_backpressure();

      wait_until_idle();
      if (failures == 0 && expected_results.size() == 0) begin
         $display("content_length_frame_parser_tb OK");
      end else begin
         $display("content_length_frame_parser_tb NOT OK");
      end
      $finish;
   end

endmodule
